[src/envelope_deframer_macros.svh]
// Assertion macros for the envelope deframer checker.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ENVELOPE_DEFRAMER_MACROS_SVH
`define ENVELOPE_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ENVDF_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("envelope deframer check failed");

// Consequent must hold in the cycle after the antecedent.
`define ENVDF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("envelope deframer check failed");

`endif

[src/envdf_pkg.sv]
// Shared types and constants for the envelope deframer.
// Used by every RTL module and the checker.
package envdf_pkg;

    localparam int WORD_BYTES = 4;
    localparam int TIME_BYTES = 8;

    localparam logic [2:0] WORD_LAST = 3'(WORD_BYTES - 1);
    localparam logic [2:0] TIME_LAST = 3'(TIME_BYTES - 1);

    typedef enum logic [3:0] {
        PH_SID_LEN = 4'd0,
        PH_SID     = 4'd1,
        PH_INDEX   = 4'd2,
        PH_COUNTER = 4'd3,
        PH_TIME    = 4'd4,
        PH_ID_LEN  = 4'd5,
        PH_ID      = 4'd6,
        PH_AAD_LEN = 4'd7,
        PH_AAD     = 4'd8,
        PH_CT_LEN  = 4'd9,
        PH_CT      = 4'd10,
        PH_DONE    = 4'd11
    } phase_t;

    localparam logic [2:0] KIND_SID   = 3'd0;
    localparam logic [2:0] KIND_ID    = 3'd1;
    localparam logic [2:0] KIND_AAD   = 3'd2;
    localparam logic [2:0] KIND_CT    = 3'd3;
    localparam logic [2:0] KIND_HDR   = 3'd4;
    localparam logic [2:0] KIND_TRAIL = 3'd5;

    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;

    typedef struct packed {
        logic [7:0] data_in;
        logic       end_in;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_out;
        logic        field_end;
        logic [31:0] msg_number;
        logic [31:0] prior_counter;
        logic [63:0] timestamp;
        logic [1:0]  status;
        logic        end_out;
    } result_t;

endpackage

[src/envdf_byte_if.sv]
// Input channel of the envelope deframer: one message byte per beat.
// Depends on nothing.
interface envdf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       end_in;

    modport source (output valid, output data_in, output end_in, input ready);
    modport sink (input valid, input data_in, input end_in, output ready);
endinterface

[src/envdf_result_if.sv]
// Result channel of the envelope deframer: one tagged byte and verdict per beat.
// Depends on nothing.
interface envdf_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_out;
    logic        field_end;
    logic [31:0] msg_number;
    logic [31:0] prior_counter;
    logic [63:0] timestamp;
    logic [1:0]  status;
    logic        end_out;

    modport source (
        output valid, output kind, output data_out, output field_end,
        output msg_number, output prior_counter, output timestamp,
        output status, output end_out, input ready
    );
    modport sink (
        input valid, input kind, input data_out, input field_end,
        input msg_number, input prior_counter, input timestamp,
        input status, input end_out, output ready
    );
endinterface

[src/envelope_deframer.sv]
// The envelope deframer takes one message byte per beat and returns one tagged result
// per byte, at a sustained rate of one byte per clock cycle while the sink is ready.
// A byte is registered on entry, parsed by the phase logic in the following cycle and
// held in the result register until the sink takes it. Payload bytes are passed on
// before the verdict on the final byte, so a consumer must discard them when that
// verdict reports truncation. State returns to its reset value after every final byte.
// Depends on envdf_pkg, envdf_byte_if, envdf_result_if and the three stage modules.
module envelope_deframer
    import envdf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    envdf_byte_if.sink      bytes,
    envdf_result_if.source  results
);

    in_beat_t beat;
    logic     beat_valid;
    logic     beat_take;
    result_t  res;
    logic     res_ready;

    envdf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .beat       (beat),
        .beat_valid (beat_valid),
        .beat_take  (beat_take)
    );

    envdf_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .beat_valid (beat_valid),
        .res_ready  (res_ready),
        .beat_take  (beat_take),
        .res        (res)
    );

    envdf_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .res_valid  (beat_valid),
        .res_ready  (res_ready),
        .results    (results)
    );

endmodule

[src/envdf_in_stage.sv]
// Input register of the envelope deframer: captures one byte beat.
// Depends on envdf_pkg and envdf_byte_if.
module envdf_in_stage
    import envdf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    envdf_byte_if.sink   bytes,
    output in_beat_t     beat,
    output logic         beat_valid,
    input  logic         beat_take
);

    in_beat_t beat_reg;
    logic     valid_reg;

    // The register frees up in the same cycle its content moves on.
    assign bytes.ready = !valid_reg || beat_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (bytes.valid && bytes.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (beat_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            beat_reg.data_in <= bytes.data_in;
            beat_reg.end_in  <= bytes.end_in;
        end
    end

    assign beat       = beat_reg;
    assign beat_valid = valid_reg;

endmodule

[src/envdf_parse.sv]
// Envelope parser: phase state, header assembly and payload length tracking.
// Depends on envdf_pkg. Updates its state once for every byte it passes on.
module envdf_parse
    import envdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_beat_t beat,
    input  logic     beat_valid,
    input  logic     res_ready,
    output logic     beat_take,
    output result_t  res
);

    phase_t      phase_reg,   phase_next;
    logic [2:0]  hbc_reg,     hbc_next;
    logic [31:0] rem_reg,     rem_next;
    logic [63:0] asm_reg,     asm_next;
    logic [31:0] index_reg,   index_next;
    logic [31:0] counter_reg, counter_next;
    logic [63:0] time_reg,    time_next;

    logic [63:0] shifted;
    logic [31:0] word;
    logic        hdr_done;
    logic        is_hdr;
    logic        is_pay;
    phase_t      pay_after;
    logic [2:0]  kind;
    logic        fend;

    assign beat_take = beat_valid && res_ready;

    assign shifted  = {asm_reg[55:0], beat.data_in};
    assign word     = shifted[31:0];
    assign hdr_done = (phase_reg == PH_TIME) ? (hbc_reg == TIME_LAST) : (hbc_reg >= WORD_LAST);

    always_comb
    begin
        phase_next   = phase_reg;
        hbc_next     = hbc_reg;
        rem_next     = rem_reg;
        asm_next     = asm_reg;
        index_next   = index_reg;
        counter_next = counter_reg;
        time_next    = time_reg;
        is_hdr       = 1'b0;
        is_pay       = 1'b0;
        pay_after    = PH_DONE;
        kind         = KIND_TRAIL;
        fend         = 1'b0;

        unique case (phase_reg)
            PH_SID_LEN:
            begin
                is_hdr = 1'b1;
                if (hdr_done)
                begin
                    rem_next   = word;
                    phase_next = (word == 32'd0) ? PH_INDEX : PH_SID;
                end
            end
            PH_INDEX:
            begin
                is_hdr = 1'b1;
                if (hdr_done)
                begin
                    index_next = word;
                    phase_next = PH_COUNTER;
                end
            end
            PH_COUNTER:
            begin
                is_hdr = 1'b1;
                if (hdr_done)
                begin
                    counter_next = word;
                    phase_next   = PH_TIME;
                end
            end
            PH_TIME:
            begin
                is_hdr = 1'b1;
                if (hdr_done)
                begin
                    time_next  = shifted;
                    phase_next = PH_ID_LEN;
                end
            end
            PH_ID_LEN:
            begin
                is_hdr = 1'b1;
                if (hdr_done)
                begin
                    rem_next   = word;
                    phase_next = (word == 32'd0) ? PH_AAD_LEN : PH_ID;
                end
            end
            PH_AAD_LEN:
            begin
                is_hdr = 1'b1;
                if (hdr_done)
                begin
                    rem_next   = word;
                    phase_next = (word == 32'd0) ? PH_CT_LEN : PH_AAD;
                end
            end
            PH_CT_LEN:
            begin
                is_hdr = 1'b1;
                if (hdr_done)
                begin
                    rem_next   = word;
                    phase_next = (word == 32'd0) ? PH_DONE : PH_CT;
                end
            end
            PH_SID:
            begin
                is_pay    = 1'b1;
                kind      = KIND_SID;
                pay_after = PH_INDEX;
            end
            PH_ID:
            begin
                is_pay    = 1'b1;
                kind      = KIND_ID;
                pay_after = PH_AAD_LEN;
            end
            PH_AAD:
            begin
                is_pay    = 1'b1;
                kind      = KIND_AAD;
                pay_after = PH_CT_LEN;
            end
            PH_CT:
            begin
                is_pay    = 1'b1;
                kind      = KIND_CT;
                pay_after = PH_DONE;
            end
            default:
            begin
                // Trailing bytes after the ciphertext, and unused codes.
                kind = KIND_TRAIL;
            end
        endcase

        if (is_hdr)
        begin
            kind = KIND_HDR;
            if (hdr_done)
            begin
                asm_next = '0;
                hbc_next = '0;
            end
            else
            begin
                asm_next = shifted;
                hbc_next = 3'(hbc_reg + 3'd1);
            end
        end

        if (is_pay)
        begin
            if (rem_reg <= 32'd1)
            begin
                rem_next   = '0;
                fend       = 1'b1;
                phase_next = pay_after;
            end
            else
            begin
                rem_next = 32'(rem_reg - 32'd1);
            end
        end
    end

    always_comb
    begin
        res.kind          = kind;
        res.data_out      = beat.data_in;
        res.field_end     = fend;
        res.msg_number    = '0;
        res.prior_counter = '0;
        res.timestamp     = '0;
        res.status        = ST_PROGRESS;
        res.end_out       = beat.end_in;
        if (beat.end_in)
        begin
            if (phase_next == PH_DONE)
            begin
                res.status        = ST_COMPLETE;
                res.msg_number    = index_next;
                res.prior_counter = counter_next;
                res.timestamp     = time_next;
            end
            else
            begin
                res.status = ST_TRUNC;
            end
        end
    end

    // The final byte of a message returns every register to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SID_LEN;
            hbc_reg     <= '0;
            rem_reg     <= '0;
            asm_reg     <= '0;
            index_reg   <= '0;
            counter_reg <= '0;
            time_reg    <= '0;
        end
        else if (beat_take)
        begin
            if (beat.end_in)
            begin
                phase_reg   <= PH_SID_LEN;
                hbc_reg     <= '0;
                rem_reg     <= '0;
                asm_reg     <= '0;
                index_reg   <= '0;
                counter_reg <= '0;
                time_reg    <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                hbc_reg     <= hbc_next;
                rem_reg     <= rem_next;
                asm_reg     <= asm_next;
                index_reg   <= index_next;
                counter_reg <= counter_next;
                time_reg    <= time_next;
            end
        end
    end

endmodule

[src/envdf_out_stage.sv]
// Result register of the envelope deframer: holds one result beat for the sink.
// Depends on envdf_pkg and envdf_result_if.
module envdf_out_stage
    import envdf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  result_t         res,
    input  logic            res_valid,
    output logic            res_ready,
    envdf_result_if.source  results
);

    result_t res_reg;
    logic    valid_reg;

    assign res_ready = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign results.valid         = valid_reg;
    assign results.kind          = res_reg.kind;
    assign results.data_out      = res_reg.data_out;
    assign results.field_end     = res_reg.field_end;
    assign results.msg_number    = res_reg.msg_number;
    assign results.prior_counter = res_reg.prior_counter;
    assign results.timestamp     = res_reg.timestamp;
    assign results.status        = res_reg.status;
    assign results.end_out       = res_reg.end_out;

endmodule

[src/envdf_checker.sv]
// Port-level checks for the envelope deframer, bound to the top level.
// Depends on envdf_pkg and envelope_deframer_macros.svh.
`include "envelope_deframer_macros.svh"

module envdf_checker
    import envdf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  data_out,
    input logic        field_end,
    input logic [31:0] msg_number,
    input logic [31:0] prior_counter,
    input logic [63:0] timestamp,
    input logic [1:0]  status,
    input logic        end_out
);

    // A result the sink has not taken stays put.
    `ENVDF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(data_out) && $stable(kind) && $stable(status))

    // A verdict appears exactly on the final byte of a message.
    `ENVDF_ASSERT_NOW(a_verdict, out_valid, (status == ST_PROGRESS) == !end_out)

    // Header values are shown only with a complete envelope.
    `ENVDF_ASSERT_NOW(a_values, out_valid && status != ST_COMPLETE, msg_number == 32'd0 && prior_counter == 32'd0 && timestamp == 64'd0)

    // Only payload bytes can close a field.
    `ENVDF_ASSERT_NOW(a_fend, out_valid && field_end, kind == KIND_SID || kind == KIND_ID || kind == KIND_AAD || kind == KIND_CT)

endmodule

bind envelope_deframer envdf_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .kind          (results.kind),
    .data_out      (results.data_out),
    .field_end     (results.field_end),
    .msg_number    (results.msg_number),
    .prior_counter (results.prior_counter),
    .timestamp     (results.timestamp),
    .status        (results.status),
    .end_out       (results.end_out)
);
